// ===== src/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// shared types and codes for the priority ready queue core
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int TASK_BITS = 4;
    localparam int OUT_CNT_BITS = 5;

    typedef enum logic [1:0] {
        C_HOLD,
        C_INS,
        C_POP,
        C_ROT
    } t_cell_op;

    // per-cell control, driven by the sequencer
    typedef struct packed {
        t_cell_op op;
        logic     in_use;
        logic     tail;
    } t_cell_ctl;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_ENQ    = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// ===== src/prq_cell.sv =====
// ----------------------------------------------------------------------------
// prq_cell
// one slot of a sorted list: holds key and data, trades with its neighbors
// ----------------------------------------------------------------------------
module prq_cell import prq_pkg::*; #(
    parameter int KEY_BITS  = 8,
    parameter int DATA_BITS = 4
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [KEY_BITS-1:0]  i_new_key,
    input  logic [DATA_BITS-1:0] i_new_data,
    input  logic [KEY_BITS-1:0]  i_left_key,
    input  logic [DATA_BITS-1:0] i_left_data,
    input  logic                 i_left_stay,
    input  logic [KEY_BITS-1:0]  i_right_key,
    input  logic [DATA_BITS-1:0] i_right_data,
    output logic [KEY_BITS-1:0]  o_key,
    output logic [DATA_BITS-1:0] o_data,
    output logic                 o_stay
);

    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [DATA_BITS-1:0] r_data, n_data;

    // entry stays put when it sorts at or before the new item
    assign o_stay = i_ctl.in_use && (r_key <= i_new_key);

    always_comb begin
        n_key  = r_key;
        n_data = r_data;
        unique case (i_ctl.op)
            C_HOLD: begin
            end
            C_INS: begin
                if (!o_stay) begin
                    if (i_left_stay) begin
                        n_key  = i_new_key;
                        n_data = i_new_data;
                    end else begin
                        n_key  = i_left_key;
                        n_data = i_left_data;
                    end
                end
            end
            C_POP, C_ROT: begin
                if (i_ctl.op == C_ROT && i_ctl.tail) begin
                    n_key  = i_new_key;
                    n_data = i_new_data;
                end else begin
                    n_key  = i_right_key;
                    n_data = i_right_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
    end

    assign o_key  = r_key;
    assign o_data = r_data;

endmodule

// ===== src/priority_ready_queue_with_arrivals_core.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_with_arrivals_core
// task scheduler with a sorted ready list and a sorted waiting list
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  command   start, busy, i_command .. i_arrival_delay taken on start & !busy
//  result    o_valid, o_head_task .. o_released_count  one-cycle strobe
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data      valid & ready
//
//  create, enqueue and pop go from accept through the report state to the result strobe
//  in a tick the waiting list rotates through
//  its head cell one entry per cycle, set by the single head examine point,
//  and the tick closes once the countdown of entries runs out
//  reset is synchronous, lists come up empty, fallback task is 1
//  results cannot be held off; the strobe lasts one cycle
//  no clearing pass: list contents are only read below the occupancy
// ----------------------------------------------------------------------------
module priority_ready_queue_with_arrivals_core import prq_pkg::*; #(
    parameter int MAX_TASKS  = 16,
    parameter int PRIO_BITS  = 8,
    parameter int DELAY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_arrival_delay,
    output logic        o_valid,
    output logic [3:0]  o_head_task,
    output logic        o_ready_empty,
    output logic        o_preempt,
    output logic [1:0]  o_status,
    output logic [4:0]  o_ready_count,
    output logic [4:0]  o_waiting_count,
    output logic [4:0]  o_released_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int WD_W  = TASK_BITS + DELAY_BITS;

    typedef enum logic [1:0] {S_IDLE, S_TICK, S_REPORT} t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_rocc, n_rocc, r_wocc, n_wocc, r_cnt, n_cnt, r_rel, n_rel;
    logic             r_pre, n_pre;
    logic [1:0]       r_status, n_status;
    logic [3:0]       r_fallback, n_fallback;

    // registered result
    logic             r_valid, n_valid;
    logic [3:0]       r_head, n_head;
    logic             r_empty, n_empty;
    logic             r_o_pre, n_o_pre;
    logic [1:0]       r_o_status, n_o_status;
    logic [4:0]       r_o_rc, n_o_rc, r_o_wc, n_o_wc, r_o_rel, n_o_rel;

    // chain wiring
    logic [PRIO_BITS-1:0]  rd_key [MAX_TASKS];
    logic [TASK_BITS-1:0]  rd_id  [MAX_TASKS];
    logic                  rd_stay[MAX_TASKS];
    logic [PRIO_BITS-1:0]  wt_key [MAX_TASKS];
    logic [WD_W-1:0]       wt_data[MAX_TASKS];
    logic                  wt_stay[MAX_TASKS];

    t_cell_op              rd_op, wt_op;
    logic [IDX_W-1:0]      wt_tail;
    logic [PRIO_BITS-1:0]  rd_new_key, wt_new_key;
    logic [TASK_BITS-1:0]  rd_new_id;
    logic [WD_W-1:0]       wt_new_data;

    logic [PRIO_BITS-1:0]  in_key;
    logic [DELAY_BITS-1:0] in_delay;
    logic [DELAY_BITS-1:0] wh_delay, wh_dec;
    logic [TASK_BITS-1:0]  wh_id;
    logic                  rd_full, wt_full;

    assign in_key   = PRIO_BITS'(i_priority_req);
    assign in_delay = DELAY_BITS'(i_arrival_delay);
    assign wh_delay = wt_data[0][DELAY_BITS-1:0];
    assign wh_id    = wt_data[0][WD_W-1:DELAY_BITS];
    // countdown saturates at zero
    assign wh_dec   = (wh_delay != '0) ? wh_delay - 1'b1 : wh_delay;
    assign rd_full  = (r_rocc == CNT_W'(MAX_TASKS));
    assign wt_full  = (r_wocc == CNT_W'(MAX_TASKS));

    // ready and waiting rows
    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cells
        t_cell_ctl             rc, wc;
        logic [PRIO_BITS-1:0]  rl_key, rr_key, wl_key, wr_key;
        logic [TASK_BITS-1:0]  rl_id, rr_id;
        logic [WD_W-1:0]       wl_data, wr_data;
        logic                  rl_stay, wl_stay;

        assign rc.op     = rd_op;
        assign rc.in_use = (r_rocc > CNT_W'(g));
        assign rc.tail   = 1'b0;
        assign wc.op     = wt_op;
        assign wc.in_use = (r_wocc > CNT_W'(g));
        assign wc.tail   = (wt_tail == IDX_W'(g));

        if (g == 0) begin : g_first
            // head cell: nothing to its left, insert lands here directly
            assign rl_stay = 1'b1;
            assign rl_key  = rd_new_key;
            assign rl_id   = rd_new_id;
            assign wl_stay = 1'b1;
            assign wl_key  = wt_new_key;
            assign wl_data = wt_new_data;
        end else begin : g_mid
            assign rl_stay = rd_stay[g-1];
            assign rl_key  = rd_key[g-1];
            assign rl_id   = rd_id[g-1];
            assign wl_stay = wt_stay[g-1];
            assign wl_key  = wt_key[g-1];
            assign wl_data = wt_data[g-1];
        end

        if (g == MAX_TASKS - 1) begin : g_last
            assign rr_key  = rd_key[g];
            assign rr_id   = rd_id[g];
            assign wr_key  = wt_key[g];
            assign wr_data = wt_data[g];
        end else begin : g_inner
            assign rr_key  = rd_key[g+1];
            assign rr_id   = rd_id[g+1];
            assign wr_key  = wt_key[g+1];
            assign wr_data = wt_data[g+1];
        end

        prq_cell #(.KEY_BITS(PRIO_BITS), .DATA_BITS(TASK_BITS)) u_rd (
            .i_clk       (i_clk),
            .i_ctl       (rc),
            .i_new_key   (rd_new_key),
            .i_new_data  (rd_new_id),
            .i_left_key  (rl_key),
            .i_left_data (rl_id),
            .i_left_stay (rl_stay),
            .i_right_key (rr_key),
            .i_right_data(rr_id),
            .o_key       (rd_key[g]),
            .o_data      (rd_id[g]),
            .o_stay      (rd_stay[g])
        );

        prq_cell #(.KEY_BITS(PRIO_BITS), .DATA_BITS(WD_W)) u_wt (
            .i_clk       (i_clk),
            .i_ctl       (wc),
            .i_new_key   (wt_new_key),
            .i_new_data  (wt_new_data),
            .i_left_key  (wl_key),
            .i_left_data (wl_data),
            .i_left_stay (wl_stay),
            .i_right_key (wr_key),
            .i_right_data(wr_data),
            .o_key       (wt_key[g]),
            .o_data      (wt_data[g]),
            .o_stay      (wt_stay[g])
        );
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_rocc     = r_rocc;
        n_wocc     = r_wocc;
        n_cnt      = r_cnt;
        n_rel      = r_rel;
        n_pre      = r_pre;
        n_status   = r_status;
        n_fallback = r_fallback;
        n_valid    = 1'b0;
        n_head     = r_head;
        n_empty    = r_empty;
        n_o_pre    = r_o_pre;
        n_o_status = r_o_status;
        n_o_rc     = r_o_rc;
        n_o_wc     = r_o_wc;
        n_o_rel    = r_o_rel;

        rd_op       = C_HOLD;
        wt_op       = C_HOLD;
        rd_new_key  = in_key;
        rd_new_id   = i_task_id;
        wt_new_key  = in_key;
        wt_new_data = {i_task_id, in_delay};
        wt_tail     = IDX_W'(r_wocc - 1'b1);

        if (i_cfg_valid) begin
            n_fallback = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pre    = 1'b0;
                    n_status = ST_OK;
                    n_rel    = '0;
                    n_state  = S_REPORT;
                    unique case (i_command)
                        CMD_CREATE, CMD_ENQ: begin
                            if (i_command == CMD_ENQ || in_delay == '0) begin
                                if (rd_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    rd_op  = C_INS;
                                    n_rocc = r_rocc + 1'b1;
                                    n_pre  = !rd_stay[0] && (r_rocc != '0);
                                end
                            end else begin
                                if (wt_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    wt_op  = C_INS;
                                    n_wocc = r_wocc + 1'b1;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (r_rocc == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                rd_op  = C_POP;
                                n_rocc = r_rocc - 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            n_cnt   = r_wocc;
                            n_state = S_TICK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                // examine the waiting head, release it or rotate it to the tail
                rd_new_key  = wt_key[0];
                rd_new_id   = wh_id;
                wt_new_key  = wt_key[0];
                wt_new_data = {wh_id, wh_dec};
                if (r_cnt == '0) begin
                    n_state = S_REPORT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (wh_dec == '0 && !rd_full) begin
                        rd_op  = C_INS;
                        wt_op  = C_POP;
                        n_rocc = r_rocc + 1'b1;
                        n_wocc = r_wocc - 1'b1;
                        n_rel  = r_rel + 1'b1;
                        n_pre  = r_pre || (!rd_stay[0] && (r_rocc != '0));
                    end else begin
                        wt_op = C_ROT;
                        if (wh_dec == '0) begin
                            n_status = ST_FULL;
                        end
                    end
                end
            end
            S_REPORT: begin
                n_valid    = 1'b1;
                n_head     = (r_rocc != '0) ? rd_id[0] : r_fallback;
                n_empty    = (r_rocc == '0);
                n_o_pre    = r_pre;
                n_o_status = r_status;
                n_o_rc     = OUT_CNT_BITS'(r_rocc);
                n_o_wc     = OUT_CNT_BITS'(r_wocc);
                n_o_rel    = OUT_CNT_BITS'(r_rel);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rocc     <= '0;
            r_wocc     <= '0;
            r_cnt      <= '0;
            r_rel      <= '0;
            r_pre      <= 1'b0;
            r_status   <= ST_OK;
            r_fallback <= 4'd1;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rocc     <= n_rocc;
            r_wocc     <= n_wocc;
            r_cnt      <= n_cnt;
            r_rel      <= n_rel;
            r_pre      <= n_pre;
            r_status   <= n_status;
            r_fallback <= n_fallback;
            r_valid    <= n_valid;
        end
        r_head     <= n_head;
        r_empty    <= n_empty;
        r_o_pre    <= n_o_pre;
        r_o_status <= n_o_status;
        r_o_rc     <= n_o_rc;
        r_o_wc     <= n_o_wc;
        r_o_rel    <= n_o_rel;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_valid;
    assign o_head_task      = r_head;
    assign o_ready_empty    = r_empty;
    assign o_preempt        = r_o_pre;
    assign o_status         = r_o_status;
    assign o_ready_count    = r_o_rc;
    assign o_waiting_count  = r_o_wc;
    assign o_released_count = r_o_rel;

endmodule

// ===== src/prq_checker.sv =====
// ----------------------------------------------------------------------------
// prq_checker
// port-level checks for the priority ready queue core
// ----------------------------------------------------------------------------
module prq_checker import prq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_ready_empty,
    input logic        o_preempt,
    input logic [1:0]  o_status,
    input logic [4:0]  o_ready_count
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ready_empty == (o_ready_count == 5'd0)))
        else $error("empty flag disagrees with count");

    a_preempt_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_preempt |-> !o_ready_empty) else $error("preempt on empty list");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_ready_empty) else $error("pop error with tasks");

endmodule

bind priority_ready_queue_with_arrivals_core prq_checker u_prq_checker (.*);
